@@ hw/rtl/bbvp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbvp_pkg
// Shared types and constants of the basic block vector profiler.
// ----------------------------------------------------------------------------
package bbvp_pkg;

    localparam int MAX_BLOCKS_DEF = 63;
    localparam int PC_W           = 32;
    localparam int LEN_W          = 16;
    localparam int CNT_W          = 32;
    localparam int BID_W          = 6;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic FUNC_COMMIT = 1'b0;
    localparam logic FUNC_DUMP   = 1'b1;

    localparam logic REC_COUNT = 1'b0;
    localparam logic REC_MARK  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_CNT_RD,
        S_CNT_WR,
        S_DUMP,
        S_MARK
    } t_state;

    // count store commands: read, write and clear
    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } t_cnt_cmd;

endpackage

@@ hw/rtl/basic_block_vector_profiler_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// basic_block_vector_profiler_core
// Basic block vector builder: PC to ID lookup, saturating interval counters
// and dump of nonzero counters followed by an end-of-interval marker.
// ----------------------------------------------------------------------------
// One item at a time. A commit searches the known PCs one entry per cycle
// through the PC table's single read port, then reads and writes the count
// table. A dump walks the count table one entry per cycle, holding while a
// nonzero record waits on a stalled output side. Results sit in an output
// register, so the next item is taken while the last record still waits.
// ----------------------------------------------------------------------------
module basic_block_vector_profiler_core #(
    parameter int MAX_BLOCKS = bbvp_pkg::MAX_BLOCKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_func,
    input  logic [bbvp_pkg::PC_W-1:0]   i_head_pc,
    input  logic [bbvp_pkg::LEN_W-1:0]  i_block_len,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_record_kind,
    output logic [bbvp_pkg::BID_W-1:0]  o_block_id,
    output logic [bbvp_pkg::CNT_W-1:0]  o_block_count,
    output logic                        o_overflow,
    output logic                        o_last
);
    import bbvp_pkg::*;

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] USED_MAX = CW'(MAX_BLOCKS);

    t_state           r_state, n_state;
    logic [PC_W-1:0]  r_pc, n_pc;
    logic [LEN_W-1:0] r_len, n_len;
    logic [CW-1:0]    r_used, n_used;
    logic [CW-1:0]    r_idx, n_idx;
    logic [IW-1:0]    r_cidx, n_cidx;
    logic             r_cvld, n_cvld;
    logic [IW-1:0]    r_slot, n_slot;
    logic             r_ovf, n_ovf;
    logic             r_ovalid, n_ovalid;
    logic             r_okind, n_okind;
    logic [BID_W-1:0] r_oid, n_oid;
    logic [CNT_W-1:0] r_ocnt, n_ocnt;
    logic             r_oovf, n_oovf;
    logic             r_olast, n_olast;

    logic             pc_wr, pc_rd;
    logic [IW-1:0]    pc_wr_addr, pc_rd_addr;
    logic [PC_W-1:0]  pc_rd_data;
    t_cnt_cmd         cnt_cmd;
    logic [IW-1:0]    cnt_rd_addr, cnt_wr_addr;
    logic [CNT_W-1:0] cnt_wr_data, cnt_rd_data;
    logic [CNT_W:0]   sum;
    logic             out_free, nz, hit;

    bbvp_pc_store #(.DEPTH(MAX_BLOCKS), .AW(IW)) u_pc (
        .i_clk     (i_clk),
        .i_wr      (pc_wr),
        .i_wr_addr (pc_wr_addr),
        .i_wr_data (r_pc),
        .i_rd      (pc_rd),
        .i_rd_addr (pc_rd_addr),
        .o_rd_data (pc_rd_data)
    );

    bbvp_cnt_store #(.DEPTH(MAX_BLOCKS), .AW(IW)) u_cnt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cnt_cmd),
        .i_rd_addr (cnt_rd_addr),
        .i_wr_addr (cnt_wr_addr),
        .i_wr_data (cnt_wr_data),
        .o_rd_data (cnt_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_cvld   <= 1'b0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_cvld   <= n_cvld;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pc    <= n_pc;
        r_len   <= n_len;
        r_idx   <= n_idx;
        r_cidx  <= n_cidx;
        r_slot  <= n_slot;
        r_okind <= n_okind;
        r_oid   <= n_oid;
        r_ocnt  <= n_ocnt;
        r_oovf  <= n_oovf;
        r_olast <= n_olast;
    end

    assign out_free = !r_ovalid || i_ready;
    assign hit      = r_cvld && (pc_rd_data == r_pc);
    assign nz       = r_cvld && (cnt_rd_data != '0);
    assign sum      = {1'b0, cnt_rd_data} + (CNT_W + 1)'(r_len);

    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_len    = r_len;
        n_used   = r_used;
        n_idx    = r_idx;
        n_cidx   = r_cidx;
        n_cvld   = r_cvld;
        n_slot   = r_slot;
        n_ovf    = r_ovf;
        n_ovalid = r_ovalid;
        n_okind  = r_okind;
        n_oid    = r_oid;
        n_ocnt   = r_ocnt;
        n_oovf   = r_oovf;
        n_olast  = r_olast;

        o_ready     = 1'b0;
        pc_wr       = 1'b0;
        pc_rd       = 1'b0;
        pc_wr_addr  = r_used[IW-1:0];
        pc_rd_addr  = r_idx[IW-1:0];
        cnt_cmd     = '0;
        cnt_rd_addr = r_idx[IW-1:0];
        cnt_wr_addr = r_cidx;
        cnt_wr_data = sum[CNT_W-1:0];

        // drop the shown item once taken; a load below may refill it
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_pc    = i_head_pc;
                    n_len   = i_block_len;
                    n_idx   = '0;
                    n_cvld  = 1'b0;
                    n_state = (i_func == FUNC_DUMP) ? S_DUMP : S_SRCH;
                end
            end
            S_SRCH: begin
                if (hit) begin
                    n_slot  = r_cidx;
                    n_cvld  = 1'b0;
                    n_state = S_CNT_RD;
                end else if (r_idx != r_used) begin
                    // compare last read while fetching the next entry
                    pc_rd  = 1'b1;
                    n_cidx = r_idx[IW-1:0];
                    n_cvld = 1'b1;
                    n_idx  = r_idx + CW'(1);
                end else begin
                    n_cvld = 1'b0;
                    if (r_used == USED_MAX) begin
                        n_ovf   = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        pc_wr   = 1'b1;
                        n_slot  = r_used[IW-1:0];
                        n_used  = r_used + CW'(1);
                        n_state = S_CNT_RD;
                    end
                end
            end
            S_CNT_RD: begin
                cnt_cmd.rd  = 1'b1;
                cnt_rd_addr = r_slot;
                n_state     = S_CNT_WR;
            end
            S_CNT_WR: begin
                cnt_cmd.wr  = 1'b1;
                cnt_wr_addr = r_slot;
                if (sum[CNT_W]) begin
                    cnt_wr_data = COUNT_MAX;
                    n_ovf       = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_DUMP: begin
                // hold the walk while a nonzero record waits for the output
                if (!nz || out_free) begin
                    if (nz) begin
                        n_ovalid = 1'b1;
                        n_okind  = REC_COUNT;
                        n_oid    = BID_W'(r_cidx) + BID_W'(1);
                        n_ocnt   = cnt_rd_data;
                        n_oovf   = 1'b0;
                        n_olast  = 1'b0;
                    end
                    if (r_cvld) begin
                        cnt_cmd.clr = 1'b1;
                    end
                    if (r_idx != USED_MAX) begin
                        cnt_cmd.rd = 1'b1;
                        n_cidx     = r_idx[IW-1:0];
                        n_cvld     = 1'b1;
                        n_idx      = r_idx + CW'(1);
                    end else begin
                        n_cvld  = 1'b0;
                        n_state = S_MARK;
                    end
                end
            end
            S_MARK: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = REC_MARK;
                    n_oid    = '0;
                    n_ocnt   = '0;
                    n_oovf   = r_ovf;
                    n_olast  = 1'b1;
                    n_ovf    = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid       = r_ovalid;
    assign o_record_kind = r_okind;
    assign o_block_id    = r_oid;
    assign o_block_count = r_ocnt;
    assign o_overflow    = r_oovf;
    assign o_last        = r_olast;

endmodule

@@ hw/rtl/bbvp_pc_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbvp_pc_store
// Table of known block head PCs: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bbvp_pc_store #(
    parameter int DEPTH = bbvp_pkg::MAX_BLOCKS_DEF,
    parameter int AW    = 6
) (
    input  logic                      i_clk,
    input  logic                      i_wr,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [bbvp_pkg::PC_W-1:0] i_wr_data,
    input  logic                      i_rd,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [bbvp_pkg::PC_W-1:0] o_rd_data
);
    import bbvp_pkg::*;

    logic [PC_W-1:0] r_mem [DEPTH];
    logic [PC_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/bbvp_cnt_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbvp_cnt_store
// Interval counters with per-entry valid bits; an invalid entry reads as zero.
// ----------------------------------------------------------------------------
module bbvp_cnt_store #(
    parameter int DEPTH = bbvp_pkg::MAX_BLOCKS_DEF,
    parameter int AW    = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bbvp_pkg::t_cnt_cmd         i_cmd,
    input  logic [AW-1:0]              i_rd_addr,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [bbvp_pkg::CNT_W-1:0] i_wr_data,
    output logic [bbvp_pkg::CNT_W-1:0] o_rd_data
);
    import bbvp_pkg::*;

    logic [CNT_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [CNT_W-1:0] r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.wr) begin
                r_vld[i_wr_addr] <= 1'b1;
            end else if (i_cmd.clr) begin
                r_vld[i_wr_addr] <= 1'b0;
            end
            if (i_cmd.rd) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

@@ hw/rtl/bbvp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbvp_checker
// Port-level checks of the profiler core's record stream and item handshake.
// ----------------------------------------------------------------------------
module bbvp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic        o_record_kind,
    input  logic [5:0]  o_block_id,
    input  logic [31:0] o_block_count,
    input  logic        o_overflow,
    input  logic        o_last
);
    import bbvp_pkg::*;

    // marker carries no id or count and closes the dump
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_record_kind == REC_MARK) |->
            (o_block_id == '0) && (o_block_count == '0) && o_last)
        else $error("marker record malformed");

    // count records name a real block with a nonzero count
    a_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_record_kind == REC_COUNT) |->
            (o_block_id != '0) && (o_block_count != '0) && !o_last && !o_overflow)
        else $error("count record malformed");

    // every item keeps the core busy for at least the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("item accepted back to back");

    // a stalled record holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=>
            o_valid && $stable(o_block_id) && $stable(o_block_count) && $stable(o_last))
        else $error("stalled record changed");

endmodule

bind basic_block_vector_profiler_core bbvp_checker u_bbvp_checker (.*);
